// ----- rtl/sacl_pkg.sv -----
// Shared types, constants and helper functions for the set-associative cache lookup.
`default_nettype none
package sacl_pkg;

    localparam int MAX_SETS_DEF     = 1024;
    localparam int MAX_WAYS_DEF     = 16;
    localparam int ADDRESS_BITS_DEF = 32;

    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAY_BITS   = 2'd2;

    localparam logic [2:0] BLOCK_BITS_RST = 3'd5;
    localparam logic [3:0] SET_BITS_RST   = 4'd6;
    localparam logic [2:0] WAY_BITS_RST   = 3'd2;
    localparam logic [2:0] BLOCK_BITS_MIN = 3'd3;
    localparam logic [2:0] BLOCK_BITS_MAX = 3'd6;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    // saturated split of the address
    typedef struct packed {
        logic [2:0] bb;
        logic [4:0] sb;
        logic [2:0] wb;
    } t_cfg;

    typedef struct packed {
        logic clr;
        logic accept;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_sts;

    function automatic int floor_log2(input int limit);
        int k;
        k = 0;
        for (int i = 0; i < 31; i++) begin
            if ((64'd1 << (k + 1)) <= 64'(limit)) begin
                k = k + 1;
            end
        end
        return k;
    endfunction

    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[15:1]};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sacl_ctrl.sv -----
// Controller state machine: reset clear sweep, beat acceptance, lookup sequencing.
`default_nettype none
module sacl_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire sacl_pkg::t_sts i_sts,
    output sacl_pkg::t_cmd     o_cmd
);
    import sacl_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_LOOK))
        else $error("accepted beat did not enter lookup");

    a_no_ready_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("ready raised before clear sweep");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_out_valid)
        else $error("result beat during clear sweep");

endmodule
`default_nettype wire

// ----- rtl/sacl_dp.sv -----
// Datapath: tag/valid row memory, tag compare, random fill, counters and result register.
`default_nettype none
module sacl_dp #(
    parameter int MAX_SETS     = sacl_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
    parameter int ADDRESS_BITS = sacl_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire sacl_pkg::t_cfg          i_cfg,
    input  wire sacl_pkg::t_cmd          i_cmd,
    output sacl_pkg::t_sts               o_sts,
    input  wire logic [ADDRESS_BITS-1:0] i_address,
    output logic                         o_hit,
    output logic [3:0]                   o_way,
    output logic [31:0]                  o_hit_count,
    output logic [31:0]                  o_miss_count
);
    import sacl_pkg::*;

    localparam int SMAX  = floor_log2(MAX_SETS);
    localparam int WMAX  = floor_log2(MAX_WAYS);
    localparam int ROWS  = 1 << SMAX;
    localparam int NWAYS = 1 << WMAX;
    localparam int SETW  = (SMAX > 0) ? SMAX : 1;
    localparam int TAG_W = ADDRESS_BITS - 3;

    typedef logic [NWAYS-1:0][TAG_W:0] t_row;

    t_row                     r_mem [ROWS];
    t_row                     r_row;
    t_row                     new_row;
    t_row                     mem_wdata;
    logic [SETW-1:0]          r_set;
    logic [SETW-1:0]          r_clr_idx;
    logic [SETW-1:0]          mem_waddr;
    logic [SETW-1:0]          set_idx;
    logic [TAG_W-1:0]         r_tag;
    logic [TAG_W-1:0]         tag_in;
    logic [ADDRESS_BITS-1:0]  addr_sh;
    logic [ADDRESS_BITS-1:0]  set_mask;
    logic [5:0]               tag_shamt;
    logic [4:0]               ways_n;
    logic [3:0]               way_mask;
    logic                     lk_hit;
    logic [3:0]               lk_way;
    logic [3:0]               miss_way;
    logic                     mem_we;
    logic [15:0]              r_lfsr;
    logic [31:0]              r_hits;
    logic [31:0]              r_misses;
    logic                     r_hit;
    logic [3:0]               r_way;

    always_comb begin
        addr_sh   = i_address >> i_cfg.bb;
        set_mask  = (ADDRESS_BITS'(1) << i_cfg.sb) - ADDRESS_BITS'(1);
        set_idx   = SETW'(addr_sh & set_mask);
        tag_shamt = 6'(i_cfg.bb) + 6'(i_cfg.sb);
        tag_in    = TAG_W'(i_address >> tag_shamt);
    end

    always_comb begin
        ways_n   = 5'd1 << i_cfg.wb;
        way_mask = 4'(ways_n - 5'd1);
        miss_way = r_lfsr[3:0] & way_mask;
        lk_hit   = 1'b0;
        lk_way   = '0;
        for (int w = NWAYS - 1; w >= 0; w--) begin
            if (5'(w) < ways_n && r_row[w][TAG_W] && r_row[w][TAG_W-1:0] == r_tag) begin
                lk_hit = 1'b1;
                lk_way = 4'(w);
            end
        end
        new_row = r_row;
        for (int w = 0; w < NWAYS; w++) begin
            if (4'(w) == miss_way) begin
                new_row[w] = {1'b1, r_tag};
            end
        end
        mem_we    = i_cmd.clr || (i_cmd.finish && !lk_hit);
        mem_waddr = i_cmd.clr ? r_clr_idx : r_set;
        mem_wdata = i_cmd.clr ? t_row'('0) : new_row;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept) begin
            r_row <= r_mem[set_idx];
            r_set <= set_idx;
            r_tag <= tag_in;
        end
        if (i_cmd.finish) begin
            r_hit <= lk_hit;
            r_way <= lk_hit ? lk_way : miss_way;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_lfsr    <= LFSR_SEED;
            r_hits    <= '0;
            r_misses  <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_idx <= r_clr_idx + SETW'(1);
            end
            if (i_cmd.finish) begin
                if (lk_hit) begin
                    r_hits <= r_hits + 32'd1;
                end else begin
                    r_misses <= r_misses + 32'd1;
                    r_lfsr   <= lfsr_next(r_lfsr);
                end
            end
        end
    end

    assign o_sts.clr_last = (r_clr_idx == SETW'(ROWS - 1));
    assign o_hit          = r_hit;
    assign o_way          = r_way;
    assign o_hit_count    = r_hits;
    assign o_miss_count   = r_misses;

    a_one_count_per_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_cmd.finish) |=>
            (r_hits + r_misses) == ($past(r_hits) + $past(r_misses) + 32'd1))
        else $error("counters did not advance by one");

    a_counts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !i_cmd.finish) |=> ($stable(r_hits) && $stable(r_misses)))
        else $error("counters moved without a lookup");

    a_lfsr_on_miss_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !(i_cmd.finish && !lk_hit)) |=> $stable(r_lfsr))
        else $error("lfsr stepped without a miss");

endmodule
`default_nettype wire

// ----- rtl/set_assoc_cache_lookup_random_top.sv -----
// Top level: configuration registers, controller and datapath of the cache lookup.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+------------------------------------------
//   input    | i_in_valid / o_in_ready     | i_address
//   result   | o_out_valid / i_out_ready   | o_hit, o_way, o_hit_count, o_miss_count
//   config   | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_data
//
// Each address beat is a synchronous row read of the tag/valid memory, then
// compare and write-back of the filled way on a miss.
// After reset a clear sweep writes one row per cycle over all 2^floor(log2(MAX_SETS))
// rows (1024 by default), with o_in_ready low; config writes are taken.
// A waiting result stalls the lookup stage with o_in_ready low; one more beat can still be accepted while it waits.
`default_nettype none
module set_assoc_cache_lookup_random_top #(
    parameter int MAX_SETS     = sacl_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
    parameter int ADDRESS_BITS = sacl_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [sacl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sacl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [ADDRESS_BITS-1:0]          i_address,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_hit,
    output logic [3:0]                            o_way,
    output logic [31:0]                           o_hit_count,
    output logic [31:0]                           o_miss_count
);
    import sacl_pkg::*;

    localparam int SMAX = floor_log2(MAX_SETS);
    localparam int WMAX = floor_log2(MAX_WAYS);

    logic [2:0] r_block_bits;
    logic [3:0] r_set_bits;
    logic [2:0] r_way_bits;
    t_cfg       cfg;
    t_cmd       cmd;
    t_sts       sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bits <= BLOCK_BITS_RST;
            r_set_bits   <= SET_BITS_RST;
            r_way_bits   <= WAY_BITS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_BITS: r_block_bits <= i_cfg_data[2:0];
                REG_SET_BITS:   r_set_bits   <= i_cfg_data[3:0];
                REG_WAY_BITS:   r_way_bits   <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_block_bits < BLOCK_BITS_MIN) begin
            cfg.bb = BLOCK_BITS_MIN;
        end else if (r_block_bits > BLOCK_BITS_MAX) begin
            cfg.bb = BLOCK_BITS_MAX;
        end else begin
            cfg.bb = r_block_bits;
        end
        cfg.sb = (5'(r_set_bits) > 5'(SMAX)) ? 5'(SMAX) : 5'(r_set_bits);
        cfg.wb = (r_way_bits > 3'(WMAX)) ? 3'(WMAX) : r_way_bits;
    end

    sacl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sacl_dp #(
        .MAX_SETS     (MAX_SETS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_address    (i_address),
        .o_hit        (o_hit),
        .o_way        (o_way),
        .o_hit_count  (o_hit_count),
        .o_miss_count (o_miss_count)
    );

endmodule
`default_nettype wire
